FILE: hw/rtl/sfm_pkg.sv
// Package for the simplex facet matcher: widths, sizes, key and hash helpers.
// No dependencies.
package sfm_pkg;
    localparam int VertexBits = 20;
    localparam int ElemBits   = 20;
    localparam int MaxFacets  = 4096;
    localparam int HashSlots  = 8192;
    localparam int KeyBits    = 3 * VertexBits;
    localparam int SlotBits   = $clog2(HashSlots);
    localparam int FidBits    = $clog2(MaxFacets);
    localparam int CountBits  = FidBits + 1;
    localparam int OutFidBits = 12;
    localparam logic [63:0] HashMul = 64'h9E3779B97F4A7C15;

    typedef logic [VertexBits-1:0] t_vtx;
    typedef logic [KeyBits-1:0]    t_key;
    typedef logic [SlotBits-1:0]   t_slot;

    typedef struct packed {
        logic [ElemBits-1:0]   source_elem;
        logic [1:0]            local_facet;
        logic [OutFidBits-1:0] facet_id;
        logic                  is_new;
        logic [ElemBits-1:0]   first_side_elem;
        logic                  table_full;
        logic                  last;
    } t_result;

    function automatic t_key make_key(input t_vtx v0, input t_vtx v1, input t_vtx v2,
                                      input logic [1:0] n);
        t_vtx f0, f1, f2, t;
        begin
            f0 = v0;
            f1 = (n >= 2'd2) ? v1 : '0;
            f2 = (n == 2'd3) ? v2 : '0;
            if (n >= 2'd2 && f0 > f1) begin
                t = f0; f0 = f1; f1 = t;
            end
            if (n == 2'd3 && f1 > f2) begin
                t = f1; f1 = f2; f2 = t;
            end
            if (n == 2'd3 && f0 > f1) begin
                t = f0; f0 = f1; f1 = t;
            end
            make_key = {f2, f1, f0};
        end
    endfunction
endpackage

FILE: hw/rtl/sfm_hash.sv
// Hash start slot: key times golden constant, high word, low slot bits.
// Two-stage partial product unit, one result per request. Uses sfm_pkg.
module sfm_hash (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  sfm_pkg::t_key i_key,
    output logic          o_done,
    output sfm_pkg::t_slot o_slot
);
    import sfm_pkg::*;
    // Only product bits [32+SlotBits-1:32] matter; split key in 32-bit halves.
    logic [63:0] r_p0, r_p1, r_p2;
    logic        r_v1, r_v2;
    logic [63:0] key64;
    logic [63:0] sum;
    assign key64 = 64'(i_key);
    always_ff @(posedge i_clk) begin
        r_p0 <= key64[31:0] * HashMul[31:0];
        r_p1 <= 64'(key64[31:0] * HashMul[63:32]);
        r_p2 <= 64'(key64[63:32] * HashMul[31:0]);
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end
    assign sum = r_p0 + {r_p1[31:0], 32'd0} + {r_p2[31:0], 32'd0};
    always_ff @(posedge i_clk) o_slot <= sum[32 +: SlotBits];
    assign o_done = r_v2;
endmodule

FILE: hw/rtl/simplex_facet_matcher.sv
// Simplex facet matcher top level: control sequencer, slot and side memories.
// Uses sfm_pkg and sfm_hash.
//
// Each element produces one facet result more than the configured dimension
// (two when the dimension is 0). A new facet, or one that finds the table full,
// passes through hashing the key, checking the home slot and issuing the result.
// A found facet adds a side memory read, and each further probe of the slot
// table (linear probing, one slot per probe) adds a probe step and a check. An
// element is accepted, then its facets are processed one after another.
// A facet waits in the check step while the previous result is not taken.
// After reset and after a clear request, a sweep over all 8192 slots empties
// the slot valid memory before the next element is probed.
module simplex_facet_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [103:0] s_axis_tdata, // elem_index, vertex_a..vertex_d, pad
    input  logic        s_axis_tuser,  // clear_first
    input  logic        s_axis_tlast,  // final_element
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // source_elem, local_facet, facet_id,
                                       // first_side_elem, pad
    output logic [1:0]  m_axis_tuser,  // is_new, table_full
    output logic        m_axis_tlast   // last
);
    import sfm_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_HASH = 7'b0000100,
        S_PROBE = 7'b0001000, S_CHECK = 7'b0010000, S_SIDE = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    logic [1:0] r_dim;
    logic [ElemBits-1:0] r_elem;
    t_vtx r_v [4];
    logic [1:0] r_j, r_dimeff;
    t_key r_key;
    t_slot r_slot, r_clr;
    logic [SlotBits:0] r_probes;
    logic [CountBits-1:0] r_count;
    logic r_hstart;
    logic r_hgo;
    t_result r_res;
    logic r_ovalid;
    logic r_elem_ok;

    // Slot memory: valid, key, facet id in one word.
    logic [KeyBits+FidBits:0] slot_mem [HashSlots];
    logic [KeyBits+FidBits:0] r_slot_rd;
    logic [ElemBits-1:0] side_mem [MaxFacets];
    logic [ElemBits-1:0] r_side_rd;

    logic hdone;
    t_slot hslot;
    sfm_hash u_hash (.i_clk, .i_rst_n, .i_start(r_hgo), .i_key(r_key),
                     .o_done(hdone), .o_slot(hslot));

    t_vtx k0, k1, k2;
    always_comb begin
        k0 = (r_j == 2'd0) ? r_v[1] : r_v[0];
        k1 = (r_j <= 2'd1) ? r_v[2] : r_v[1];
        k2 = (r_j <= 2'd2) ? r_v[3] : r_v[2];
    end

    logic rd_valid;
    logic [KeyBits-1:0] rd_key;
    logic [FidBits-1:0] rd_fid;
    assign rd_valid = r_slot_rd[KeyBits+FidBits];
    assign rd_key = r_slot_rd[KeyBits+FidBits-1:FidBits];
    assign rd_fid = r_slot_rd[FidBits-1:0];

    logic slot_we;
    logic [KeyBits+FidBits:0] slot_wd;
    t_slot slot_wa;
    logic side_we;
    logic [FidBits-1:0] side_a;
    logic [ElemBits-1:0] side_wd;
    logic ins_ok;
    assign ins_ok = !r_count[FidBits];

    always_comb begin
        slot_we = 1'b0; slot_wa = r_slot; slot_wd = {1'b1, r_key, r_count[FidBits-1:0]};
        side_we = 1'b0; side_a = rd_fid; side_wd = r_elem;
        if (r_state == S_CLEAR) begin
            slot_we = 1'b1; slot_wa = r_clr; slot_wd = '0;
        end else if (r_state == S_CHECK && !r_ovalid && !rd_valid && ins_ok) begin
            slot_we = 1'b1; side_we = 1'b1; side_a = r_count[FidBits-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) slot_mem[slot_wa] <= slot_wd;
        r_slot_rd <= slot_mem[(r_state == S_HASH && hdone) ? hslot : r_slot];
        if (side_we) side_mem[side_a] <= side_wd;
        r_side_rd <= side_mem[side_a];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {2'd0, r_res.first_side_elem, r_res.facet_id,
                           r_res.local_facet, r_res.source_elem};
    assign m_axis_tuser = {r_res.table_full, r_res.is_new};
    assign m_axis_tlast = r_res.last;

    logic hstart_set;
    assign hstart_set =
        (r_state == S_CLEAR && r_clr == t_slot'(HashSlots - 1) && r_elem_ok)
        || (r_state == S_IDLE && s_axis_tvalid && !s_axis_tuser)
        || (r_state == S_OUT && !r_ovalid && r_j != r_dimeff);

    // Delay the hash start through r_hstart and r_hgo so the key register has settled before the hash samples it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hstart <= 1'b0;
            r_hgo <= 1'b0;
        end else begin
            r_hstart <= hstart_set;
            r_hgo <= r_hstart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_dim <= 2'd3; r_count <= '0;
            r_ovalid <= 1'b0; r_j <= '0;
        end else begin
            if (i_cfg_valid) r_dim <= i_cfg_data;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == t_slot'(HashSlots - 1)) begin
                        if (r_elem_ok) r_state <= S_HASH;
                        else r_state <= S_IDLE;
                    end
                end
                S_IDLE: if (s_axis_tvalid) begin
                    r_elem <= s_axis_tdata[19:0];
                    r_v[0] <= s_axis_tdata[39:20]; r_v[1] <= s_axis_tdata[59:40];
                    r_v[2] <= s_axis_tdata[79:60]; r_v[3] <= s_axis_tdata[99:80];
                    r_j <= '0;
                    r_dimeff <= (r_dim == 2'd0) ? 2'd1 : r_dim;
                    r_clr <= '0;
                    if (s_axis_tuser) begin
                        r_count <= '0; r_state <= S_CLEAR;
                    end else r_state <= S_HASH;
                end
                S_HASH: begin
                    if (hdone) begin
                        r_slot <= hslot; r_probes <= '0; r_state <= S_CHECK;
                    end
                end
                S_PROBE: r_state <= S_CHECK;
                S_CHECK: if (!r_ovalid) begin
                    if (rd_valid && rd_key != r_key) begin
                        if (r_probes == (SlotBits+1)'(HashSlots - 1)) begin
                            r_res.table_full <= 1'b1; r_res.is_new <= 1'b0;
                            r_res.facet_id <= '0; r_res.first_side_elem <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_probes <= r_probes + 1'b1;
                            r_slot <= r_slot + 1'b1;
                            r_state <= S_PROBE;
                        end
                    end else if (rd_valid) begin
                        r_res.table_full <= 1'b0; r_res.is_new <= 1'b0;
                        r_res.facet_id <= OutFidBits'(rd_fid);
                        r_state <= S_SIDE;
                    end else if (ins_ok) begin
                        r_res.table_full <= 1'b0; r_res.is_new <= 1'b1;
                        r_res.facet_id <= OutFidBits'(r_count[FidBits-1:0]);
                        r_res.first_side_elem <= r_elem;
                        r_count <= r_count + 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_res.table_full <= 1'b1; r_res.is_new <= 1'b0;
                        r_res.facet_id <= '0; r_res.first_side_elem <= '0;
                        r_state <= S_OUT;
                    end
                    r_res.source_elem <= r_elem;
                    r_res.local_facet <= r_j;
                    r_res.last <= (r_j == r_dimeff);
                end
                S_SIDE: begin
                    r_res.first_side_elem <= r_side_rd;
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                    if (r_j == r_dimeff) r_state <= S_IDLE;
                    else begin
                        r_j <= r_j + 1'b1; r_state <= S_HASH;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // element present flag for the post-clear resume
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_elem_ok <= 1'b0;
        else if (r_state == S_IDLE && s_axis_tvalid) r_elem_ok <= 1'b1;
        else if (r_state == S_OUT && !r_ovalid && r_j == r_dimeff) r_elem_ok <= 1'b0;
    end

    always_ff @(posedge i_clk) r_key <= make_key(k0, k1, k2, r_dimeff);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid && $stable(r_res))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountBits'(MaxFacets))
        else $error("facet count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK && r_ovalid |=> r_state == S_CHECK)
        else $error("facet checked while a result waits");
endmodule
